// ===== design/battery_level_estimator_macros.svh =====
// Assertion macros shared by the battery level estimator RTL
`ifndef BATTERY_LEVEL_ESTIMATOR_MACROS_SVH
`define BATTERY_LEVEL_ESTIMATOR_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define BLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define BLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/ble_pkg.sv =====
// Package with types, constants and the charge curve of the battery level estimator
`default_nettype none
package ble_pkg;
  localparam int SAMPLE_BITS_C = 12;
  localparam logic [13:0] MV_MAX = 14'd16383;

  typedef enum logic [2:0] {
    REG_BURST_LEN, REG_FULL_SCALE, REG_DIV_NUM, REG_DIV_DEN, REG_EMA_DIV
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_AVG, ST_MUL_FS, ST_DIV_FS, ST_MUL_NUM, ST_DIV_DEN,
    ST_EMA_SUB, ST_DIV_EMA, ST_EMA_ADD, ST_PCT_MUL, ST_PCT_DIV, ST_OUT
  } ble_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_DIV_AVG, OP_MUL_FS, OP_DIV_FS, OP_MUL_NUM, OP_DIV_DEN,
    OP_EMA_SUB, OP_DIV_EMA, OP_EMA_ADD, OP_PCT_MUL, OP_PCT_DIV, OP_EMPTY
  } ble_op_t;

  typedef struct packed {
    ble_op_t op;
    logic    div_start;
    logic    out_load;
  } ble_cmd_t;

  typedef struct packed {
    logic div_done;
    logic empty;
  } ble_sts_t;

  function automatic logic [12:0] knee_mv(input logic [3:0] k);
    logic [12:0] r;
    begin
      case (k)
        4'd0: r = 13'd4200;  4'd1: r = 13'd4100;  4'd2: r = 13'd4000;
        4'd3: r = 13'd3950;  4'd4: r = 13'd3900;  4'd5: r = 13'd3850;
        4'd6: r = 13'd3800;  4'd7: r = 13'd3750;  4'd8: r = 13'd3700;
        4'd9: r = 13'd3650;  4'd10: r = 13'd3600; 4'd11: r = 13'd3550;
        4'd12: r = 13'd3500; 4'd13: r = 13'd3400; 4'd14: r = 13'd3300;
        default: r = 13'd3000;
      endcase
      return r;
    end
  endfunction

  function automatic logic [6:0] knee_pct(input logic [3:0] k);
    logic [6:0] r;
    begin
      case (k)
        4'd0: r = 7'd100; 4'd1: r = 7'd92;  4'd2: r = 7'd85;  4'd3: r = 7'd78;
        4'd4: r = 7'd70;  4'd5: r = 7'd62;  4'd6: r = 7'd55;  4'd7: r = 7'd48;
        4'd8: r = 7'd42;  4'd9: r = 7'd35;  4'd10: r = 7'd28; 4'd11: r = 7'd20;
        4'd12: r = 7'd14; 4'd13: r = 7'd8;  4'd14: r = 7'd4;
        default: r = 7'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ===== design/ble_if.sv =====
// Valid/ready channel interfaces for samples and results
`default_nettype none
interface ble_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] raw_sample;
  logic        sample_ok;
  modport source (output valid, raw_sample, sample_ok, input ready);
  modport sink (input valid, raw_sample, sample_ok, output ready);
endinterface

interface ble_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] filtered_mv;
  logic [13:0] cell_mv;
  logic [11:0] average_raw;
  logic [6:0]  charge_percent;
  logic        status;
  modport source (output valid, filtered_mv, cell_mv, average_raw, charge_percent, status,
                  input ready);
  modport sink (input valid, filtered_mv, cell_mv, average_raw, charge_percent, status,
                output ready);
endinterface
`default_nettype wire

// ===== design/battery_level_estimator.sv =====
// Battery level estimator top level
// out_valid rises once the burst-end computation after a burst's last sample is done;
// a burst with no good sample skips the averaging, scaling and filter steps.
// Throughput: one sample per cycle inside a burst, then the burst-end computation.
// A burst's last sample waits while the previous result is unread.
// Synchronous active-low reset restores register defaults and clears the filter.
`default_nettype none
module battery_level_estimator
  import ble_pkg::*;
#(
  parameter int MAX_BURST = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  ble_in_if.sink          in_ch,
  ble_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [11:0] cfg_wdata
);
  logic [4:0]  burst_len_r;
  logic [11:0] full_scale_r;
  logic [2:0]  div_num_r, div_den_r;
  logic [4:0]  ema_div_r;
  logic        acc_en, acc_clear;
  ble_cmd_t    cmd;
  ble_sts_t    sts;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_len_r <= 5'd16;
      full_scale_r <= 12'd2450;
      div_num_r <= 3'd2;
      div_den_r <= 3'd1;
      ema_div_r <= 5'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BURST_LEN:  burst_len_r <= cfg_wdata[4:0];
        REG_FULL_SCALE: full_scale_r <= cfg_wdata;
        REG_DIV_NUM:    div_num_r <= cfg_wdata[2:0];
        REG_DIV_DEN:    div_den_r <= cfg_wdata[2:0];
        REG_EMA_DIV:    ema_div_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  ble_ctrl #(.MAX_BURST(MAX_BURST)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .burst_len(burst_len_r),
    .empty(sts.empty), .div_done(sts.div_done), .acc_en(acc_en),
    .acc_clear(acc_clear), .cmd(cmd)
  );

  ble_datapath #(.MAX_BURST(MAX_BURST)) u_dp (
    .clk(clk), .rst_n(rst_n), .acc_en(acc_en), .raw_sample(in_ch.raw_sample),
    .sample_ok(in_ch.sample_ok), .acc_clear(acc_clear), .full_scale_mv(full_scale_r),
    .divider_num(div_num_r), .divider_den(div_den_r), .ema_divisor(ema_div_r),
    .cmd(cmd), .sts(sts), .filtered_mv(out_ch.filtered_mv), .cell_mv(out_ch.cell_mv),
    .average_raw(out_ch.average_raw), .charge_percent(out_ch.charge_percent),
    .status(out_ch.status)
  );
endmodule
`default_nettype wire

// ===== design/ble_div.sv =====
// Shared restoring divider, one quotient bit per cycle
`default_nettype none
module ble_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] trial;

  // Shift one dividend bit in, subtract when it fits
  always_comb begin
    trial = {rem_r[15:0], q_r[31]};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd1);
  assign quotient = q_nxt;
endmodule
`default_nettype wire

// ===== design/ble_datapath.sv =====
// Datapath: burst accumulation, scaling, filter and charge curve
`default_nettype none
module ble_datapath
  import ble_pkg::*;
#(
  parameter int MAX_BURST = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc_en,
  input  wire logic [11:0] raw_sample,
  input  wire logic        sample_ok,
  input  wire logic        acc_clear,
  input  wire logic [11:0] full_scale_mv,
  input  wire logic [2:0]  divider_num,
  input  wire logic [2:0]  divider_den,
  input  wire logic [4:0]  ema_divisor,
  input  wire ble_cmd_t    cmd,
  output ble_sts_t         sts,
  output logic [13:0]      filtered_mv,
  output logic [13:0]      cell_mv,
  output logic [11:0]      average_raw,
  output logic [6:0]       charge_percent,
  output logic             status
);
  localparam int CW = $clog2(MAX_BURST + 1);
  localparam int SW = 12 + CW;

  logic [SW-1:0] sum_r;
  logic [CW-1:0] cnt_r;
  logic [13:0]   filt_r;
  logic [31:0]   acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic [3:0]    seg_r;
  logic [31:0]   div_a;
  logic [15:0]   div_b;
  logic          div_done;
  logic [31:0]   div_q;
  logic [13:0]   filt_nxt;
  logic [11:0]   avg_nxt;
  logic [13:0]   cell_nxt;
  logic [3:0]    seg_nxt;
  logic [6:0]    pct_nxt;
  logic [14:0]   ema_new;
  logic [24:0]   fs_sum;

  // Accumulate good samples of the current burst
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (acc_clear) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (acc_en && sample_ok) begin
      sum_r <= sum_r + SW'(raw_sample);
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // Divider operand select
  always_comb begin
    div_a = acc_r;
    div_b = 16'd1;
    unique case (cmd.op)
      OP_DIV_AVG: begin div_a = 32'(sum_r); div_b = 16'(cnt_r); end
      OP_DIV_DEN: div_b = (divider_den == 3'd0) ? 16'd1 : 16'(divider_den);
      OP_DIV_EMA: div_b = (ema_divisor == 5'd0) ? 16'd1 : 16'(ema_divisor);
      OP_PCT_DIV: div_b = 16'(knee_mv(seg_r - 4'd1) - knee_mv(seg_r));
      default: ;
    endcase
  end

  ble_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  // Find the curve segment of a filter value
  always_comb begin
    seg_nxt = 4'd15;
    for (int k = 14; k >= 0; k--) begin
      if ({1'b0, filt_nxt} >= 15'(knee_mv(4'(k)))) seg_nxt = 4'(k);
    end
  end

  // Sequence one operation per command
  always_comb begin
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    filt_nxt = filt_r;
    avg_nxt = average_raw;
    cell_nxt = cell_mv;
    pct_nxt = charge_percent;
    ema_new = 15'd0;
    // Divide by the full code 4095: (x + (x >> 12) + 1) >> 12 is exact below 4095 * 4096
    fs_sum = 25'(acc_r[23:0]) + 25'(acc_r[23:12]) + 25'd1;
    unique case (cmd.op) inside
      OP_DIV_AVG: if (div_done) begin
        avg_nxt = div_q[11:0];
        acc_nxt = 32'(div_q[11:0]);
      end
      OP_MUL_FS:  acc_nxt = 32'(acc_r[11:0] * full_scale_mv);
      OP_DIV_FS:  acc_nxt = 32'(fs_sum[24:12]);
      OP_DIV_DEN, OP_DIV_EMA, OP_PCT_DIV: if (div_done) acc_nxt = div_q;
      OP_MUL_NUM: acc_nxt = 32'(acc_r[11:0] * divider_num);
      OP_EMA_SUB: begin
        cell_nxt = (acc_r > 32'(MV_MAX)) ? MV_MAX : acc_r[13:0];
        neg_nxt = (cell_nxt < filt_r);
        acc_nxt = neg_nxt ? 32'(filt_r - cell_nxt) : 32'(cell_nxt - filt_r);
        // Seed the filter with the first reading and add nothing to it
        if (filt_r == 14'd0) begin
          filt_nxt = cell_nxt;
          acc_nxt = '0;
        end
      end
      OP_EMA_ADD: begin
        ema_new = neg_r ? (15'(filt_r) - 15'(acc_r[13:0])) : (15'(filt_r) + 15'(acc_r[13:0]));
        filt_nxt = ema_new[14] ? MV_MAX : ema_new[13:0];
      end
      OP_PCT_MUL: acc_nxt = 32'(({1'b0, filt_r} - 15'(knee_mv(seg_r)))
                                * 7'(knee_pct(seg_r - 4'd1) - knee_pct(seg_r)));
      OP_EMPTY: begin
        avg_nxt = '0;
        cell_nxt = '0;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      if (filt_r == 14'd0 || filt_r >= 14'd4200) pct_nxt = 7'd100;
      else if (filt_r < 14'd3000) pct_nxt = 7'd0;
      else pct_nxt = knee_pct(seg_r) + div_q[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else begin
      filt_r <= filt_nxt;
    end
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
    seg_r <= seg_nxt;
    average_raw <= avg_nxt;
    cell_mv <= cell_nxt;
    charge_percent <= pct_nxt;
    if (cmd.out_load) status <= (cnt_r == '0);
  end

  assign filtered_mv = filt_r;
  assign sts.div_done = div_done;
  assign sts.empty = (cnt_r == '0);
endmodule
`default_nettype wire

// ===== design/ble_ctrl.sv =====
// Controller: burst counting and burst-end computation sequencing
`default_nettype none
`include "battery_level_estimator_macros.svh"
module ble_ctrl
  import ble_pkg::*;
#(
  parameter int MAX_BURST = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire logic [4:0] burst_len,
  input  wire logic       empty,
  input  wire logic       div_done,
  output logic            acc_en,
  output logic            acc_clear,
  output ble_cmd_t        cmd
);
  localparam int CW = $clog2(MAX_BURST + 1);

  ble_state_t state_r, state_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic          empty_r, empty_nxt;
  logic [6:0]    len;
  logic          last;
  logic          div_done_seen_r;

  // Clamp the burst length into range
  always_comb begin
    len = 7'(burst_len);
    if (len == 7'd0) len = 7'd1;
    if (len > 7'(MAX_BURST)) len = 7'(MAX_BURST);
  end

  // Accept samples only while idle; hold only the burst-ending request while a result waits
  assign in_ready = (state_r == ST_IDLE) && !(ovalid_r && last);
  assign acc_en = in_valid && in_ready;
  assign last = (7'(pos_r) + 7'd1) >= len;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    ovalid_nxt = ovalid_r && !out_ready;
    empty_nxt = empty_r;
    acc_clear = 1'b0;
    cmd = '{op: OP_NONE, div_start: 1'b0, out_load: 1'b0};
    unique case (state_r)
      ST_IDLE: if (acc_en) begin
        if (last) begin
          pos_nxt = '0;
          state_nxt = ST_DIV_AVG;
        end else begin
          pos_nxt = pos_r + CW'(1);
        end
      end
      ST_DIV_AVG: begin
        // Empty burst hands the filter value straight out
        empty_nxt = empty;
        if (empty) begin
          cmd.op = OP_EMPTY;
          state_nxt = ST_PCT_MUL;
        end else begin
          cmd.op = OP_DIV_AVG;
          cmd.div_start = 1'b1;
          state_nxt = ST_MUL_FS;
        end
      end
      ST_MUL_FS: begin
        cmd.op = OP_DIV_AVG;
        if (div_done) state_nxt = ST_DIV_FS;
      end
      ST_DIV_FS: begin
        cmd.op = OP_MUL_FS;
        state_nxt = ST_MUL_NUM;
      end
      ST_MUL_NUM: begin
        cmd.op = OP_DIV_FS;
        state_nxt = ST_DIV_DEN;
      end
      ST_DIV_DEN: begin
        cmd.op = OP_MUL_NUM;
        state_nxt = ST_EMA_SUB;
      end
      ST_EMA_SUB: begin
        cmd.op = OP_DIV_DEN;
        cmd.div_start = !div_done_seen_r;
        if (div_done) state_nxt = ST_DIV_EMA;
      end
      ST_DIV_EMA: begin
        cmd.op = OP_EMA_SUB;
        state_nxt = ST_EMA_ADD;
      end
      ST_EMA_ADD: begin
        cmd.op = OP_DIV_EMA;
        cmd.div_start = !div_done_seen_r;
        if (div_done) state_nxt = ST_PCT_MUL;
      end
      ST_PCT_MUL: begin
        cmd.op = empty_r ? OP_NONE : OP_EMA_ADD;
        state_nxt = ST_PCT_DIV;
      end
      ST_PCT_DIV: begin
        cmd.op = OP_PCT_MUL;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.op = OP_PCT_DIV;
        cmd.div_start = !div_done_seen_r;
        if (div_done) begin
          cmd.out_load = 1'b1;
          ovalid_nxt = 1'b1;
          acc_clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Track whether the current divide has been launched
  always_ff @(posedge clk) begin
    if (!rst_n) div_done_seen_r <= 1'b0;
    else if (state_nxt != state_r) div_done_seen_r <= 1'b0;
    else if (cmd.div_start) div_done_seen_r <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r <= '0;
      ovalid_r <= 1'b0;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      ovalid_r <= ovalid_nxt;
      empty_r <= empty_nxt;
    end
  end

  `BLE_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, !in_ready)
  `BLE_ASSERT_NXT(a_result_on_finish, clk, rst_n, cmd.out_load, out_valid)
  `BLE_ASSERT_IMP(a_pos_in_range, clk, rst_n, 1'b1, 7'(pos_r) < 7'(MAX_BURST))
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the battery level estimator: burst averaging, filtering and charge curve
`timescale 1ns / 100ps
module tb_top;
  import ble_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [11:0] raw_sample;
    logic        sample_ok;
  } sample_t;

  typedef struct packed {
    logic [13:0] filtered_mv;
    logic [13:0] cell_mv;
    logic [11:0] average_raw;
    logic [6:0]  charge_percent;
    logic        status;
  } reading_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [11:0] cfg_wdata;

  ble_in_if in_ch ();
  ble_out_if out_ch ();

  battery_level_estimator uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow registers and state of the estimator
  int unsigned burst_len = 16, full_scale = 2450, div_num = 2, div_den = 1, ema_div = 4;
  int unsigned acc_sum = 0, acc_count = 0, acc_pos = 0, filter_mv = 0;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int mismatches = 0, bursts_seen = 0, empty_seen = 0, cycles = 0;
  int stall_hold;
  logic send_enable, long_stall_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned knee_mv_tb(input int unsigned k);
    int unsigned t[16] = '{4200, 4100, 4000, 3950, 3900, 3850, 3800, 3750,
                           3700, 3650, 3600, 3550, 3500, 3400, 3300, 3000};
    return t[k];
  endfunction

  function automatic int unsigned knee_pct_tb(input int unsigned k);
    int unsigned t[16] = '{100, 92, 85, 78, 70, 62, 55, 48, 42, 35, 28, 20, 14, 8, 4, 0};
    return t[k];
  endfunction

  // Charge percentage from the sixteen-knee discharge curve
  function automatic int unsigned soc_from_mv(input int unsigned mv);
    int unsigned k;
    if (mv == 0) return 100;
    if (mv >= knee_mv_tb(0)) return 100;
    for (k = 1; k < 16; k++) begin
      if (mv >= knee_mv_tb(k))
        return knee_pct_tb(k) + ((mv - knee_mv_tb(k)) * (knee_pct_tb(k - 1) - knee_pct_tb(k)))
               / (knee_mv_tb(k - 1) - knee_mv_tb(k));
    end
    return 0;
  endfunction

  task automatic set_register(input logic [2:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[11:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BURST_LEN: burst_len = val & 32'h1F;
      REG_FULL_SCALE: full_scale = val & 32'hFFF;
      REG_DIV_NUM: div_num = val & 32'h7;
      REG_DIV_DEN: div_den = val & 32'h7;
      REG_EMA_DIV: ema_div = val & 32'h1F;
      default: ;
    endcase
  endtask

  // Advance the burst model on one accepted sample
  task automatic predict_sample(input sample_t s);
    int unsigned len, avg, adc_mv, cell_mv_v, den, dv;
    int f, delta;
    reading_t r;
    len = (burst_len == 0) ? 1 : (burst_len > 16 ? 16 : burst_len);
    if (s.sample_ok) begin
      acc_sum += s.raw_sample;
      acc_count++;
    end
    acc_pos++;
    if (acc_pos < len) return;
    if (acc_count == 0) begin
      r.filtered_mv = filter_mv[13:0];
      r.cell_mv = '0;
      r.average_raw = '0;
      r.charge_percent = 7'(soc_from_mv(filter_mv));
      r.status = 1'b1;
    end else begin
      avg = acc_sum / acc_count;
      adc_mv = (avg * full_scale) / 4095;
      den = (div_den != 0) ? div_den : 1;
      cell_mv_v = (adc_mv * div_num) / den;
      if (cell_mv_v > 16383) cell_mv_v = 16383;
      if (filter_mv == 0) filter_mv = cell_mv_v;
      else begin
        dv = (ema_div != 0) ? ema_div : 1;
        f = int'(filter_mv);
        delta = (int'(cell_mv_v) - f) / int'(dv);
        f += delta;
        if (f < 0) f = 0;
        if (f > 16383) f = 16383;
        filter_mv = unsigned'(f);
      end
      r.filtered_mv = filter_mv[13:0];
      r.cell_mv = cell_mv_v[13:0];
      r.average_raw = avg[11:0];
      r.charge_percent = 7'(soc_from_mv(filter_mv));
      r.status = 1'b0;
    end
    expected_readings.push_back(r);
    acc_sum = 0;
    acc_count = 0;
    acc_pos = 0;
  endtask

  // Driver: offer queued requests in bursts with random gaps
  int gap_left, burst_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.raw_sample <= '0;
      in_ch.sample_ok <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_sample({in_ch.raw_sample, in_ch.sample_ok});
        void'(pending_samples.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the request
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (send_enable && pending_samples.size() > 0) begin
        sample_t nx;
        nx = pending_samples[0];
        in_ch.valid <= 1'b1;
        in_ch.raw_sample <= nx.raw_sample;
        in_ch.sample_ok <= nx.sample_ok;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          if ($urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 12);
        end else burst_left <= burst_left - 1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall on its own pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_hold <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        reading_t got, want;
        got = {out_ch.filtered_mv, out_ch.cell_mv, out_ch.average_raw,
               out_ch.charge_percent, out_ch.status};
        bursts_seen++;
        if (got.status) empty_seen++;
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected reading %h", got);
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp f=%0d c=%0d a=%0d p=%0d s=%0d got f=%0d c=%0d a=%0d p=%0d s=%0d",
                       want.filtered_mv, want.cell_mv, want.average_raw, want.charge_percent,
                       want.status, got.filtered_mv, got.cell_mv, got.average_raw,
                       got.charge_percent, got.status);
          end
        end
      end
      if (long_stall_req && stall_hold == 0) begin
        stall_hold <= 3000;
        out_ch.ready <= 1'b0;
      end else if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        out_ch.ready <= 1'b0;
      end else if (cycles % 200 < 60) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_sample(input int unsigned raw, input bit ok);
    sample_t s;
    s.raw_sample = raw[11:0];
    s.sample_ok = ok;
    pending_samples.push_back(s);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: queue_sample($urandom_range(0, 4095), 1'b0);
        1: queue_sample($urandom_range(0, 1) ? 4095 : 0, 1'b1);
        default: queue_sample($urandom_range(2800, 4095), $urandom_range(0, 7) != 0);
      endcase
    end
  endtask

  initial begin
    int p;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_enable = 1'b0;
    long_stall_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty burst first, then extremes in two-sample bursts, other registers at reset values
    set_register(REG_BURST_LEN, 2);
    queue_sample(4095, 1'b0); queue_sample(0, 1'b0);
    queue_sample(0, 1'b1); queue_sample(0, 1'b1);
    queue_sample(4095, 1'b1); queue_sample(4095, 1'b1);
    queue_sample(2730, 1'b1); queue_sample(1234, 1'b0);
    send_enable = 1'b1;
    wait_idle();
    // Saturated cell voltage and unit EMA weight
    set_register(REG_FULL_SCALE, 4095);
    set_register(REG_DIV_NUM, 7);
    set_register(REG_DIV_DEN, 1);
    set_register(REG_EMA_DIV, 1);
    set_register(REG_BURST_LEN, 1);
    queue_sample(4095, 1'b1); queue_sample(2048, 1'b1); queue_sample(1, 1'b1);
    wait_idle();
    // Zero and out-of-range register values, long burst
    set_register(REG_BURST_LEN, 31);
    set_register(REG_DIV_DEN, 0);
    set_register(REG_EMA_DIV, 0);
    set_register(REG_DIV_NUM, 0);
    for (p = 0; p < 16; p++) queue_sample(p * 256 + 255, p[0]);
    wait_idle();
    set_register(REG_BURST_LEN, 0);
    set_register(REG_FULL_SCALE, 0);
    queue_sample(3000, 1'b1);
    wait_idle();

    // Random phases over several settings
    for (p = 0; p < 8; p++) begin
      set_register(REG_BURST_LEN, (p == 0) ? 16 : (p == 1 ? 1 : $urandom_range(1, 16)));
      set_register(REG_FULL_SCALE, (p == 2) ? 1 : (p == 3 ? 4095 : $urandom_range(1800, 2600)));
      set_register(REG_DIV_NUM, (p == 4) ? 4 : $urandom_range(1, 4));
      set_register(REG_DIV_DEN, (p == 5) ? 4 : $urandom_range(1, 4));
      set_register(REG_EMA_DIV, (p == 6) ? 16 : $urandom_range(1, 16));
      if (p == 3) long_stall_req = 1'b1;
      random_phase(65);
      if (p == 5) begin
        // pause the sender until every reading is back
        while (pending_samples.size() != 0) @(posedge clk);
        send_enable = 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        send_enable = 1'b1;
      end
      random_phase(65);
      if (p == 3) begin
        while (stall_hold == 0) @(posedge clk);
        long_stall_req = 1'b0;
      end
      wait_idle();
    end

    $display("covered %0d burst readings, %0d of them with no good sample", bursts_seen,
             empty_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
